### hdl/spms_pkg.sv
// Shared types and constants for the shared-pool multi-stack unit.
package spms_pkg;

  // Width of the stack selector field and number of addressable stacks
  localparam int unsigned StackIdW = 2;
  localparam int unsigned NumIds   = 1 << StackIdW;

  // Width of a stored word
  localparam int unsigned DataW = 32;

  // Command codes
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### hdl/shared_pool_multi_stack_unit.sv
// Several stacks sharing one pool of entries, tracked by a linked free list.
//
// Usage: a command transaction enters on the s_axis channel. tuser carries
// the command (push or pop) and the stack number, tdata the word to push.
// Each command yields exactly one result transaction on the m_axis channel:
// tuser carries the status (done, pool full, stack empty), tdata the popped
// word on a successful pop and zero otherwise.
// Timing: a push or pop that changes state first reads the link and data
// memories at the chosen entry into their read registers on accept, then
// writes them back in the exec state. A refused command (pool full, empty
// or nonexistent stack) is answered on accept, with no exec state.
// The result is loaded into the output register together with the last step.
// Reset: all stacks empty and the whole pool free. No clearing pass runs;
// a fill mark stands in for the initial free-list links, so the block takes
// commands as soon as reset is released.
// Stall: the output register holds a result until it is taken; a new
// command is taken only in idle and while that register is empty or being emptied.
module shared_pool_multi_stack_unit #(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned CAPACITY   = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] value
  input  logic [spms_pkg::DataW-1:0]          s_axis_tdata_i,
  // [0] cmd, [2:1] stack_id
  input  logic [spms_pkg::StackIdW:0]         s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] data
  output logic [spms_pkg::DataW-1:0]          m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                          m_axis_tuser_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned PtrW = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] NilPtr = PtrW'(CAPACITY);
  localparam logic [6:0] NumStk = 7'(NUM_STACKS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Pool memories
  logic [spms_pkg::DataW-1:0] data_mem [CAPACITY];
  logic [PtrW-1:0]            link_mem [CAPACITY];
  logic [spms_pkg::DataW-1:0] data_rd_q;
  logic [PtrW-1:0]            link_rd_q;

  // Control and pointer state
  state_e                     state_q, state_d;
  logic [PtrW-1:0]            free_head_q, free_head_d;
  logic [PtrW-1:0]            fill_q, fill_d;
  logic [PtrW-1:0]            top_q [spms_pkg::NumIds];
  logic [PtrW-1:0]            top_d [spms_pkg::NumIds];
  logic                       m_valid_q, m_valid_d;
  logic [1:0]                 m_status_q, m_status_d;
  logic [spms_pkg::DataW-1:0] m_data_q, m_data_d;

  // Held command
  spms_pkg::cmd_e                cmd_q, cmd_d;
  logic [spms_pkg::StackIdW-1:0] sid_q, sid_d;
  logic [spms_pkg::DataW-1:0]    val_q, val_d;
  logic [IdxW-1:0]               ix_q, ix_d;
  logic                          fresh_q, fresh_d;

  // Decode of the incoming transaction
  spms_pkg::cmd_e                in_cmd;
  logic [spms_pkg::StackIdW-1:0] in_sid;
  logic                          in_accept;
  logic                          sid_ok;
  logic [PtrW-1:0]               in_ptr;
  logic                          in_fail;

  // Memory access controls
  logic            mem_we;
  logic            data_we;
  logic [PtrW-1:0] link_wdata;
  logic [PtrW-1:0] link_val;

  assign in_cmd    = spms_pkg::cmd_e'(s_axis_tuser_i[0]);
  assign in_sid    = s_axis_tuser_i[spms_pkg::StackIdW:1];
  assign s_axis_tready_o = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign sid_ok    = 7'(in_sid) < NumStk;
  assign in_ptr    = (in_cmd == spms_pkg::CMD_PUSH) ? free_head_q : top_q[in_sid];
  assign in_fail   = !sid_ok || (in_ptr >= NilPtr);

  // Link of an entry never written since reset is its successor index
  assign link_val  = fresh_q ? (PtrW'(ix_q) + PtrW'(1)) : link_rd_q;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = m_data_q;

  // Next-state logic: accept in idle, write back in exec
  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    top_d       = top_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_status_d  = m_status_q;
    m_data_d    = m_data_q;
    cmd_d       = cmd_q;
    sid_d       = sid_q;
    val_d       = val_q;
    ix_d        = ix_q;
    fresh_d     = fresh_q;
    mem_we      = 1'b0;
    data_we     = 1'b0;
    link_wdata  = top_q[sid_q];
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d   = in_cmd;
          sid_d   = in_sid;
          val_d   = s_axis_tdata_i;
          ix_d    = in_ptr[IdxW-1:0];
          fresh_d = in_ptr >= fill_q;
          if (in_fail) begin
            // Refuse at once
            m_valid_d  = 1'b1;
            m_data_d   = '0;
            m_status_d = (in_cmd == spms_pkg::CMD_PUSH) ? spms_pkg::ST_FULL
                                                        : spms_pkg::ST_EMPTY;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d    = S_IDLE;
        mem_we     = 1'b1;
        m_valid_d  = 1'b1;
        m_status_d = spms_pkg::ST_DONE;
        if (cmd_q == spms_pkg::CMD_PUSH) begin
          // Take the free head, link it above the old top
          data_we      = 1'b1;
          link_wdata   = top_q[sid_q];
          free_head_d  = link_val;
          top_d[sid_q] = PtrW'(ix_q);
          m_data_d     = '0;
          if (fresh_q) begin
            fill_d = fill_q + PtrW'(1);
          end
        end else begin
          // Unlink the top and return it to the free list
          link_wdata   = free_head_q;
          top_d[sid_q] = link_val;
          free_head_d  = PtrW'(ix_q);
          m_data_d     = data_rd_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < int'(spms_pkg::NumIds); i++) begin
        top_q[i] <= NilPtr;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      m_valid_q   <= m_valid_d;
      top_q       <= top_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_data_q   <= m_data_d;
    cmd_q      <= cmd_d;
    sid_q      <= sid_d;
    val_q      <= val_d;
    ix_q       <= ix_d;
    fresh_q    <= fresh_d;
  end

  // Link memory: read at accept, write back in exec
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[ix_q] <= link_wdata;
    end
    link_rd_q <= link_mem[in_ptr[IdxW-1:0]];
  end

  // Data memory: read at accept, write on push in exec
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[ix_q] <= val_q;
    end
    data_rd_q <= data_mem[in_ptr[IdxW-1:0]];
  end

endmodule
